/* design/dblct_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dblct_pkg
// Shared types and constants of the double-buffered label count table.
// ---------------------------------------------------------------------------
package dblct_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int IN_LABEL_BITS = 16;

    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN       = 32'sh8000_0000;
    localparam logic signed [COUNT_BITS-1:0] NOT_FOUND_COUNT = -32'sd1;
    localparam logic signed [COUNT_BITS-1:0] ZERO_COUNT      = 32'sd0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_COMMIT = 2'd2,
        OP_FLUSH  = 2'd3
    } t_opcode;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                         eval;
        logic                         apply;
        t_opcode                      op;
        logic                         add_en;
        logic                         any_hit;
        logic signed [COUNT_BITS-1:0] amount;
    } t_cell_ctrl;

endpackage
`default_nettype wire

/* design/double_buffered_label_count_table.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// double_buffered_label_count_table
// Associative label/count table with a committed copy for lookups and a
// shadow copy that gathers additions, committed or flushed on command.
// ---------------------------------------------------------------------------
// Flow: an accepted transaction passes a compare cycle, then an update
//   cycle, and its result enters the output register when the update completes.
// A new transaction is taken only when idle or alongside the update of the
//   last; a stalled result holds the update cycle.
// Reset: synchronous, active low; clears both valid bit rows at once, so
//   no clearing pass is needed. Labels and counts are not reset.
// ---------------------------------------------------------------------------
module double_buffered_label_count_table #(
    parameter int ENTRIES    = 16,
    parameter int LABEL_BITS = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    // input channel
    input  wire                                          i_valid,
    output logic                                         o_stall,
    input  wire        [1:0]                             i_opcode,
    input  wire        [dblct_pkg::IN_LABEL_BITS-1:0]    i_label,
    input  wire signed [dblct_pkg::COUNT_BITS-1:0]       i_amount,
    // result channel
    output logic                                         o_valid,
    input  wire                                          i_stall,
    output logic signed [dblct_pkg::COUNT_BITS-1:0]      o_count,
    output logic                                         o_found,
    output logic                                         o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    t_state                                    r_state;
    dblct_pkg::t_opcode                        r_op;
    logic        [LABEL_BITS-1:0]              r_label;
    logic signed [dblct_pkg::COUNT_BITS-1:0]   r_amount;
    logic                                      r_out_valid;
    logic signed [dblct_pkg::COUNT_BITS-1:0]   r_count;
    logic                                      r_found;
    logic                                      r_status;

    logic        [LABEL_BITS-1:0]              w_label;
    logic                                      w_in_acc;
    logic                                      w_out_free;
    logic                                      w_apply;
    logic                                      w_add_en;
    logic                                      w_any_hit;
    dblct_pkg::t_cell_ctrl                     w_ctrl;

    logic                                      w_free_seen [0:ENTRIES];
    logic                                      w_found     [0:ENTRIES];
    logic        [dblct_pkg::COUNT_BITS-1:0]   w_count     [0:ENTRIES];
    logic        [ENTRIES-1:0]                 w_shadow_hit;

    // Only the low LABEL_BITS bits of the label take part in matching; a wider LABEL_BITS zero-extends it
    if (LABEL_BITS <= dblct_pkg::IN_LABEL_BITS) begin : g_label_trunc
        assign w_label = i_label[LABEL_BITS-1:0];
    end else begin : g_label_ext
        assign w_label = {{(LABEL_BITS-dblct_pkg::IN_LABEL_BITS){1'b0}}, i_label};
    end

    // The output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    // Update cycle completes only when its result has somewhere to go
    assign w_apply    = (r_state == S_APPLY) && w_out_free;
    // Take a new transaction when idle, or alongside the update of the last
    assign o_stall    = !((r_state == S_IDLE) || w_apply);
    assign w_in_acc   = i_valid && !o_stall;

    // A zero amount leaves the shadow untouched
    assign w_add_en   = (r_op == dblct_pkg::OP_ADD) && (r_amount != dblct_pkg::ZERO_COUNT);
    assign w_any_hit  = |w_shadow_hit;

    always_comb begin
        w_ctrl.eval    = (r_state == S_EVAL);
        w_ctrl.apply   = w_apply;
        w_ctrl.op      = r_op;
        w_ctrl.add_en  = w_add_en;
        w_ctrl.any_hit = w_any_hit;
        w_ctrl.amount  = r_amount;
    end

    // Chain heads: nothing free seen, nothing found yet
    assign w_free_seen[0] = 1'b0;
    assign w_found[0]     = 1'b0;
    assign w_count[0]     = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dblct_cell #(
            .LABEL_BITS (LABEL_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_label      (r_label),
            .i_free_seen  (w_free_seen[g]),
            .o_free_seen  (w_free_seen[g+1]),
            .i_found      (w_found[g]),
            .o_found      (w_found[g+1]),
            .i_count      (w_count[g]),
            .o_count      (w_count[g+1]),
            .o_shadow_hit (w_shadow_hit[g])
        );
    end

    // Sequencer: state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_apply) begin
                        r_state <= w_in_acc ? S_EVAL : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op     <= dblct_pkg::t_opcode'(i_opcode);
            r_label  <= w_label;
            r_amount <= i_amount;
        end
        if (w_apply) begin
            // A lookup hit reports the gathered live count; a miss or any other op gives -1
            if ((r_op == dblct_pkg::OP_LOOKUP) && w_found[ENTRIES]) begin
                r_count <= w_count[ENTRIES];
                r_found <= 1'b1;
            end else begin
                r_count <= dblct_pkg::NOT_FOUND_COUNT;
                r_found <= 1'b0;
            end
            // Drop a new label when no shadow entry is free
            if (w_add_en && !w_any_hit && !w_free_seen[ENTRIES]) begin
                r_status <= dblct_pkg::STATUS_FULL;
            end else begin
                r_status <= dblct_pkg::STATUS_OK;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_count  = r_count;
    assign o_found  = r_found;
    assign o_status = r_status;

    // Compare cycle always advances to the update cycle
    a_eval_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_state == S_APPLY))
        else $error("compare cycle not followed by update cycle");

    // Shadow labels are unique, so at most one cell hits
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(w_shadow_hit))
        else $error("more than one shadow entry matched");

    // Commit and flush leave the shadow with free entries
    a_shadow_emptied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && ((r_op == dblct_pkg::OP_COMMIT) || (r_op == dblct_pkg::OP_FLUSH)))
        |=> w_free_seen[ENTRIES])
        else $error("shadow not emptied by commit or flush");

    // Every completed update leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> r_out_valid)
        else $error("update completed without a result");

endmodule
`default_nettype wire

/* design/dblct_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dblct_cell
// One table entry: committed and shadow label/count pairs with valid bits,
// plus its links in the free-slot and lookup-gather chains.
// ---------------------------------------------------------------------------
module dblct_cell #(
    parameter int LABEL_BITS = 16
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  dblct_pkg::t_cell_ctrl                       i_ctrl,
    input  wire        [LABEL_BITS-1:0]                 i_label,
    input  wire                                         i_free_seen,
    output logic                                        o_free_seen,
    input  wire                                         i_found,
    output logic                                        o_found,
    input  wire        [dblct_pkg::COUNT_BITS-1:0]      i_count,
    output logic       [dblct_pkg::COUNT_BITS-1:0]      o_count,
    output logic                                        o_shadow_hit
);

    logic                                      r_l_valid;
    logic                                      r_s_valid;
    logic        [LABEL_BITS-1:0]              r_l_label;
    logic        [LABEL_BITS-1:0]              r_s_label;
    logic signed [dblct_pkg::COUNT_BITS-1:0]   r_l_count;
    logic signed [dblct_pkg::COUNT_BITS-1:0]   r_s_count;
    logic                                      r_live_hit;
    logic                                      r_shadow_hit;

    logic        [dblct_pkg::COUNT_BITS:0]     w_sum;
    logic signed [dblct_pkg::COUNT_BITS-1:0]   w_sat;
    logic                                      w_claim;

    // Saturating accumulate of the shadow count
    assign w_sum = {r_s_count[dblct_pkg::COUNT_BITS-1], r_s_count}
                 + {i_ctrl.amount[dblct_pkg::COUNT_BITS-1], i_ctrl.amount};

    always_comb begin
        if (w_sum[dblct_pkg::COUNT_BITS] != w_sum[dblct_pkg::COUNT_BITS-1]) begin
            w_sat = w_sum[dblct_pkg::COUNT_BITS] ? dblct_pkg::COUNT_MIN
                                                 : dblct_pkg::COUNT_MAX;
        end else begin
            w_sat = w_sum[dblct_pkg::COUNT_BITS-1:0];
        end
    end

    // Lowest free entry takes a new label
    assign w_claim     = !i_ctrl.any_hit && !r_s_valid && !i_free_seen;
    assign o_free_seen = i_free_seen || !r_s_valid;

    assign o_found      = i_found || r_live_hit;
    assign o_count      = i_count | (r_live_hit ? r_l_count : dblct_pkg::ZERO_COUNT);
    assign o_shadow_hit = r_shadow_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_ctrl.apply) begin
            case (i_ctrl.op)
                dblct_pkg::OP_ADD: begin
                    if (i_ctrl.add_en) begin
                        if (r_shadow_hit && (w_sat == dblct_pkg::ZERO_COUNT)) begin
                            r_s_valid <= 1'b0;
                        end else if (w_claim) begin
                            r_s_valid <= 1'b1;
                        end
                    end
                end
                dblct_pkg::OP_COMMIT: begin
                    r_l_valid <= r_s_valid;
                    r_s_valid <= 1'b0;
                end
                dblct_pkg::OP_FLUSH: begin
                    r_s_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval) begin
            r_live_hit   <= r_l_valid && (r_l_label == i_label);
            r_shadow_hit <= r_s_valid && (r_s_label == i_label);
        end
        if (i_ctrl.apply) begin
            case (i_ctrl.op)
                dblct_pkg::OP_ADD: begin
                    if (i_ctrl.add_en) begin
                        if (r_shadow_hit) begin
                            r_s_count <= w_sat;
                        end else if (w_claim) begin
                            r_s_label <= i_label;
                            r_s_count <= i_ctrl.amount;
                        end
                    end
                end
                dblct_pkg::OP_COMMIT: begin
                    r_l_label <= r_s_label;
                    r_l_count <= r_s_count;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire
